/* hdl/ypvm_pkg.sv */
// Shared types and constants for the yaw/pitch view matrix block.
package ypvm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 32;
    localparam int AXIS_W     = 16;
    localparam int PH_W       = 31;
    localparam int LANES      = 4;

    localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << 30;

    localparam logic [PH_W-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [PH_W-1:0] SIN_C3 = 31'd693598670;
    localparam logic [PH_W-1:0] SIN_C5 = 31'd85569306;
    localparam logic [PH_W-1:0] SIN_C7 = 31'd5026995;
    localparam logic [PH_W-1:0] SIN_C9 = 31'd172272;

    localparam logic [PH_W-1:0] HORNER_C [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

    typedef struct packed {
        logic        [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } t_request;

    typedef struct packed {
        logic signed [AXIS_W-1:0]     right_x;
        logic signed [AXIS_W-1:0]     right_y;
        logic signed [AXIS_W-1:0]     right_z;
        logic signed [AXIS_W-1:0]     up_x;
        logic signed [AXIS_W-1:0]     up_y;
        logic signed [AXIS_W-1:0]     up_z;
        logic signed [AXIS_W-1:0]     back_x;
        logic signed [AXIS_W-1:0]     back_y;
        logic signed [AXIS_W-1:0]     back_z;
        logic signed [COORD_BITS-1:0] shift_right;
        logic signed [COORD_BITS-1:0] shift_up;
        logic signed [COORD_BITS-1:0] shift_back;
    } t_result;

    typedef struct packed {
        logic        [1:0]            q_yaw;
        logic        [1:0]            q_pitch;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } t_side;

endpackage

/* hdl/yaw_pitch_view_matrix.sv */
// Pipelined right-handed look-at view matrix from yaw, pitch and eye position.
// Throughput: one request per cycle, set by the eleven-stage datapath; busy stays low.
// The result strobe o_valid lasts one cycle and cannot be held off by the receiver.
// Reset (synchronous, active low) clears the stage valid bits only; no clearing pass.
module yaw_pitch_view_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ypvm_pkg::t_request i_req,
    output logic               o_valid,
    output ypvm_pkg::t_result  o_res
);

    localparam int AB  = ypvm_pkg::ANGLE_BITS;
    localparam int CB  = ypvm_pkg::COORD_BITS;
    localparam int PW  = CB + ypvm_pkg::AXIS_W;
    localparam int DW  = PW + 2;
    localparam int PHW = ypvm_pkg::PH_W;
    localparam int NL  = ypvm_pkg::LANES;
    localparam int NS  = 11;

    localparam logic signed [DW-1:0] SMAX = DW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] SMIN = ~SMAX;

    function automatic logic [PHW-1:0] f_horner(input logic [PHW-1:0] c,
                                                input logic [PHW-1:0] p,
                                                input logic [PHW-1:0] x2);
        logic [2*PHW-1:0] prod;
        prod = (2*PHW)'(p) * (2*PHW)'(x2);
        return c - prod[2*PHW-2:PHW-1];
    endfunction

    function automatic logic signed [35:0] f_rq14(input logic signed [35:0] v);
        return (v + 36'sd8192) >>> 14;
    endfunction

    function automatic logic signed [15:0] f_axis(input logic signed [35:0] v);
        if (v > 36'sd16384) begin
            return 16'sd16384;
        end else if (v < -36'sd16384) begin
            return -16'sd16384;
        end else begin
            return 16'(v);
        end
    endfunction

    logic                  r_v [1:NS];
    ypvm_pkg::t_side       r_side [1:9];
    logic [PHW-1:0]        r_x  [1:5][NL];
    logic [PHW-1:0]        r_x2 [1:4][NL];
    logic [PHW-1:0]        r_p  [1:5][NL];
    logic [14:0]           r_sc [NL];
    logic signed [15:0]    r_sy, r_cy, r_sp, r_cp;
    logic signed [31:0]    r_m_sc, r_m_cc;
    logic signed [15:0]    r_bx, r_by, r_bz, r_rx, r_rz;
    logic signed [15:0]    r_b9x, r_b9y, r_b9z, r_r9x, r_r9z, r_ux, r_uy, r_uz;
    logic signed [15:0]    r_b10x, r_b10y, r_b10z, r_r10x, r_r10z, r_u10x, r_u10y, r_u10z;
    logic signed [PW-1:0]  r_mul [8];
    ypvm_pkg::t_result     r_res;

    logic [PHW-1:0]        n_x [NL];
    logic                  n_take;
    logic signed [15:0]    n_sy, n_cy, n_sp, n_cp;
    logic signed [15:0]    n_rx, n_rz;
    logic signed [DW-1:0]  n_dot [3];
    logic signed [DW-1:0]  n_sh  [3];

    assign busy   = 1'b0;
    assign n_take = start && !busy;

    always_comb begin
        n_x[0] = PHW'({i_req.yaw_angle[AB-3:0], {(32-AB){1'b0}}});
        n_x[1] = ypvm_pkg::PH_ONE - n_x[0];
        n_x[2] = PHW'({i_req.pitch_angle[AB-3:0], {(32-AB){1'b0}}});
        n_x[3] = ypvm_pkg::PH_ONE - n_x[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[1] <= n_take;
            for (int s = 2; s <= NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [2*PHW-1:0] sq;
        logic [2*PHW-1:0] pr;
        logic [32:0]      rn;
        r_side[1].q_yaw   <= i_req.yaw_angle[AB-1:AB-2];
        r_side[1].q_pitch <= i_req.pitch_angle[AB-1:AB-2];
        r_side[1].px      <= i_req.pos_x;
        r_side[1].py      <= i_req.pos_y;
        r_side[1].pz      <= i_req.pos_z;
        for (int s = 2; s <= 9; s++) begin
            r_side[s] <= r_side[s-1];
        end
        for (int l = 0; l < NL; l++) begin
            sq = (2*PHW)'(n_x[l]) * (2*PHW)'(n_x[l]);
            r_x[1][l]  <= n_x[l];
            r_x2[1][l] <= sq[2*PHW-2:PHW-1];
            r_p[1][l]  <= ypvm_pkg::SIN_C9;
            for (int s = 2; s <= 4; s++) begin
                r_x2[s][l] <= r_x2[s-1][l];
            end
            for (int s = 2; s <= 5; s++) begin
                r_x[s][l]  <= r_x[s-1][l];
                r_p[s][l]  <= f_horner(ypvm_pkg::HORNER_C[s-2], r_p[s-1][l], r_x2[s-1][l]);
            end
            pr = (2*PHW)'(r_p[5][l]) * (2*PHW)'(r_x[5][l]);
            rn = (33'(pr[2*PHW-1:PHW-1]) + 33'd32768) >> 16;
            r_sc[l] <= (rn > 33'd16384) ? 15'd16384 : rn[14:0];
        end
    end

    always_comb begin
        unique case (r_side[6].q_yaw)
            2'd0: begin n_sy = 16'(r_sc[0]);  n_cy = 16'(r_sc[1]);  end
            2'd1: begin n_sy = 16'(r_sc[1]);  n_cy = -16'(r_sc[0]); end
            2'd2: begin n_sy = -16'(r_sc[0]); n_cy = -16'(r_sc[1]); end
            default: begin n_sy = -16'(r_sc[1]); n_cy = 16'(r_sc[0]); end
        endcase
        unique case (r_side[6].q_pitch)
            2'd0: begin n_sp = 16'(r_sc[2]);  n_cp = 16'(r_sc[3]);  end
            2'd1: begin n_sp = 16'(r_sc[3]);  n_cp = -16'(r_sc[2]); end
            2'd2: begin n_sp = -16'(r_sc[2]); n_cp = -16'(r_sc[3]); end
            default: begin n_sp = -16'(r_sc[3]); n_cp = 16'(r_sc[2]); end
        endcase
    end

    always_comb begin
        priority if (r_cp == 16'sd0) begin
            n_rx = 16'sd16384;
            n_rz = 16'sd0;
        end else if (r_cp > 16'sd0) begin
            n_rx = -r_cy;
            n_rz = -r_sy;
        end else begin
            n_rx = r_cy;
            n_rz = r_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sy   <= n_sy;
        r_cy   <= n_cy;
        r_sp   <= n_sp;
        r_cp   <= n_cp;
        r_m_sc <= n_sy * n_cp;
        r_m_cc <= n_cy * n_cp;

        r_bx <= f_axis(f_rq14(36'(r_m_sc)));
        r_by <= f_axis(-36'(r_sp));
        r_bz <= f_axis(f_rq14(-36'(r_m_cc)));
        r_rx <= n_rx;
        r_rz <= n_rz;

        r_b9x <= r_bx;
        r_b9y <= r_by;
        r_b9z <= r_bz;
        r_r9x <= r_rx;
        r_r9z <= r_rz;
        r_ux  <= f_axis(f_rq14(36'(r_by) * 36'(r_rz)));
        r_uy  <= f_axis(f_rq14(36'(r_bz) * 36'(r_rx) - 36'(r_bx) * 36'(r_rz)));
        r_uz  <= f_axis(f_rq14(-(36'(r_by) * 36'(r_rx))));

        r_mul[0] <= PW'(r_side[9].px) * PW'(r_r9x);
        r_mul[1] <= PW'(r_side[9].pz) * PW'(r_r9z);
        r_mul[2] <= PW'(r_side[9].px) * PW'(r_ux);
        r_mul[3] <= PW'(r_side[9].py) * PW'(r_uy);
        r_mul[4] <= PW'(r_side[9].pz) * PW'(r_uz);
        r_mul[5] <= PW'(r_side[9].px) * PW'(r_b9x);
        r_mul[6] <= PW'(r_side[9].py) * PW'(r_b9y);
        r_mul[7] <= PW'(r_side[9].pz) * PW'(r_b9z);

        r_b10x <= r_b9x;
        r_b10y <= r_b9y;
        r_b10z <= r_b9z;
        r_r10x <= r_r9x;
        r_r10z <= r_r9z;
        r_u10x <= r_ux;
        r_u10y <= r_uy;
        r_u10z <= r_uz;
    end

    always_comb begin
        n_dot[0] = DW'(r_mul[0]) + DW'(r_mul[1]);
        n_dot[1] = DW'(r_mul[2]) + DW'(r_mul[3]) + DW'(r_mul[4]);
        n_dot[2] = DW'(r_mul[5]) + DW'(r_mul[6]) + DW'(r_mul[7]);
        for (int k = 0; k < 3; k++) begin
            n_sh[k] = (DW'(8192) - n_dot[k]) >>> 14;
            if (n_sh[k] > SMAX) begin
                n_sh[k] = SMAX;
            end else if (n_sh[k] < SMIN) begin
                n_sh[k] = SMIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.right_x     <= r_r10x;
        r_res.right_y     <= 16'sd0;
        r_res.right_z     <= r_r10z;
        r_res.up_x        <= r_u10x;
        r_res.up_y        <= r_u10y;
        r_res.up_z        <= r_u10z;
        r_res.back_x      <= r_b10x;
        r_res.back_y      <= r_b10y;
        r_res.back_z      <= r_b10z;
        r_res.shift_right <= CB'(n_sh[0]);
        r_res.shift_up    <= CB'(n_sh[1]);
        r_res.shift_back  <= CB'(n_sh[2]);
    end

    assign o_valid = r_v[NS];
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##11 o_valid)
        else $error("request lost in pipeline");
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 11))
        else $error("result without request");
    a_right_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.right_y == 16'sd0 &&
                     o_res.back_y <= 16'sd16384 && o_res.back_y >= -16'sd16384))
        else $error("axis out of range");
`endif

endmodule

/* test/yaw_pitch_view_matrix_chk.sv */
// Checker for the yaw/pitch view matrix: predicts each result and compares it on arrival.
module yaw_pitch_view_matrix_chk
    import ypvm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_request i_req,
    input  logic     i_valid,
    input  t_result  i_res,
    output int       o_errors,
    output int       o_pending
);

    t_result matrix_q[$];

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd_q(longint v, int n);
        return floor_sh(v + (longint'(1) << (n - 1)), n);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint quarter_sine(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        p  = 64'(SIN_C9);
        p  = 64'(SIN_C7) - ((p * x2) >> 30);
        p  = 64'(SIN_C5) - ((p * x2) >> 30);
        p  = 64'(SIN_C3) - ((p * x2) >> 30);
        p  = 64'(SIN_C1) - ((p * x2) >> 30);
        p  = (p * x) >> 30;
        p  = (p + 64'd32768) >> 16;
        if (p > 64'd16384) begin
            p = 64'd16384;
        end
        return longint'(p);
    endfunction

    function automatic void angle_trig(input logic [ANGLE_BITS-1:0] a, output longint s,
                                       output longint c);
        logic [1:0]  q;
        logic [63:0] x;
        longint      sv;
        longint      cv;
        q  = a[ANGLE_BITS-1 -: 2];
        x  = 64'(a[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        sv = quarter_sine(x);
        cv = quarter_sine((64'd1 << 30) - x);
        case (q)
            2'd0: begin s = sv;  c = cv;  end
            2'd1: begin s = cv;  c = -sv; end
            2'd2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    function automatic longint shift_of(longint px, longint py, longint pz,
                                        longint ax, longint ay, longint az);
        longint hi;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        return clip(rnd_q(-(px * ax + py * ay + pz * az), 14), -hi - 1, hi);
    endfunction

    function automatic t_result view_of(t_request r);
        t_result m;
        longint  sy, cy, sp, cp, bx, by, bz, rx, rz, ux, uy, uz, px, py, pz;
        angle_trig(r.yaw_angle, sy, cy);
        angle_trig(r.pitch_angle, sp, cp);
        bx = clip(rnd_q(sy * cp, 14), -16384, 16384);
        by = clip(-sp, -16384, 16384);
        bz = clip(rnd_q(-(cy * cp), 14), -16384, 16384);
        if (cp == 0) begin
            rx = 16384;
            rz = 0;
        end else if (cp > 0) begin
            rx = -cy;
            rz = -sy;
        end else begin
            rx = cy;
            rz = sy;
        end
        ux = clip(rnd_q(by * rz, 14), -16384, 16384);
        uy = clip(rnd_q(bz * rx - bx * rz, 14), -16384, 16384);
        uz = clip(rnd_q(-(by * rx), 14), -16384, 16384);
        px = longint'(r.pos_x);
        py = longint'(r.pos_y);
        pz = longint'(r.pos_z);
        m.right_x     = AXIS_W'(rx);
        m.right_y     = '0;
        m.right_z     = AXIS_W'(rz);
        m.up_x        = AXIS_W'(ux);
        m.up_y        = AXIS_W'(uy);
        m.up_z        = AXIS_W'(uz);
        m.back_x      = AXIS_W'(bx);
        m.back_y      = AXIS_W'(by);
        m.back_z      = AXIS_W'(bz);
        m.shift_right = COORD_BITS'(shift_of(px, py, pz, rx, 0, rz));
        m.shift_up    = COORD_BITS'(shift_of(px, py, pz, ux, uy, uz));
        m.shift_back  = COORD_BITS'(shift_of(px, py, pz, bx, by, bz));
        return m;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("error: %s got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && i_start && !i_busy) begin
            matrix_q.push_back(view_of(i_req));
        end
        if (i_rst_n && i_valid) begin
            if (matrix_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = matrix_q.pop_front();
                if (i_res.right_x != w.right_x) report("right_x", i_res.right_x, w.right_x);
                if (i_res.right_y != w.right_y) report("right_y", i_res.right_y, w.right_y);
                if (i_res.right_z != w.right_z) report("right_z", i_res.right_z, w.right_z);
                if (i_res.up_x != w.up_x) report("up_x", i_res.up_x, w.up_x);
                if (i_res.up_y != w.up_y) report("up_y", i_res.up_y, w.up_y);
                if (i_res.up_z != w.up_z) report("up_z", i_res.up_z, w.up_z);
                if (i_res.back_x != w.back_x) report("back_x", i_res.back_x, w.back_x);
                if (i_res.back_y != w.back_y) report("back_y", i_res.back_y, w.back_y);
                if (i_res.back_z != w.back_z) report("back_z", i_res.back_z, w.back_z);
                if (i_res.shift_right != w.shift_right)
                    report("shift_right", i_res.shift_right, w.shift_right);
                if (i_res.shift_up != w.shift_up)
                    report("shift_up", i_res.shift_up, w.shift_up);
                if (i_res.shift_back != w.shift_back)
                    report("shift_back", i_res.shift_back, w.shift_back);
            end
        end
        o_pending <= matrix_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

/* test/yaw_pitch_view_matrix_tb.sv */
// Testbench top for the yaw/pitch view matrix: drives camera poses and gives the verdict.
module yaw_pitch_view_matrix_tb;
    import ypvm_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_req;
    logic     o_valid;
    t_result  o_res;
    int       errors;
    int       pending;
    int       cycles;
    bit       calm;

    yaw_pitch_view_matrix dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    yaw_pitch_view_matrix_chk u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_req    (i_req),
        .i_valid  (o_valid),
        .i_res    (o_res),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("yaw_pitch_view_matrix: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_pitch();
        case ($urandom_range(0, 7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send(input t_request r);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_request r;
        cycles  = 0;
        calm    = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 24; i++) begin
            r.yaw_angle   = 16'(i * 16384 / 4 + ((i % 3 == 0) ? 0 : 16'hffff * (i & 1)));
            case (i % 6)
                0: r.pitch_angle = 16'sd16384;
                1: r.pitch_angle = -16'sd16384;
                2: r.pitch_angle = 16'sd0;
                3: r.pitch_angle = 16'sh8000;
                4: r.pitch_angle = 16'sh7fff;
                default: r.pitch_angle = 16'sd20000;
            endcase
            r.pos_x = (i & 1) ? 32'h7fffffff : 32'h80000000;
            r.pos_y = (i & 2) ? 32'h7fffffff : 32'h80000000;
            r.pos_z = (i & 4) ? 32'h80000000 : 32'h7fffffff;
            if (i >= 20) begin
                r.pos_x = 0;
                r.pos_y = 0;
                r.pos_z = 32'hffffffff;
            end
            send(r);
        end
        for (int i = 0; i < 850; i++) begin
            calm = (i >= 300 && i < 450);
            r.yaw_angle   = 16'($urandom_range(0, 65535));
            r.pitch_angle = pick_pitch();
            r.pos_x       = pick_coord();
            r.pos_y       = pick_coord();
            r.pos_z       = pick_coord();
            send(r);
        end
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("yaw_pitch_view_matrix: match");
        end else begin
            $display("yaw_pitch_view_matrix: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/ypvm_pkg.sv
hdl/yaw_pitch_view_matrix.sv
test/yaw_pitch_view_matrix_chk.sv
test/yaw_pitch_view_matrix_tb.sv
